// ----- src/imu_serial_frame_parser_macros.svh -----
// imu_serial_frame_parser_macros.svh: assertion macros for the frame parser
// expects signals named clk and rst in the module that uses them
`ifndef IMU_SERIAL_FRAME_PARSER_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ISFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ISFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/isfp_pkg.sv -----
// isfp_pkg: types and constants shared by the frame parser modules
// no dependencies
package isfp_pkg;

  localparam int FRAME_LEN = 11;
  localparam int HELD_LEN  = FRAME_LEN - 1;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_MASK  = 8'h50;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;

  localparam logic [15:0] MAG_MUL = 16'd32768;

  // status codes
  localparam logic [2:0] ST_ACCEL    = 3'd0;
  localparam logic [2:0] ST_GYRO     = 3'd1;
  localparam logic [2:0] ST_ANGLE    = 3'd2;
  localparam logic [2:0] ST_MAG      = 3'd3;
  localparam logic [2:0] ST_OTHER    = 3'd4;
  localparam logic [2:0] ST_SYNC_ERR = 3'd5;

  // config register indexes
  localparam logic [1:0] REG_ACCEL_SCALE = 2'd0;
  localparam logic [1:0] REG_GYRO_SCALE  = 2'd1;
  localparam logic [1:0] REG_ANGLE_SCALE = 2'd2;

  localparam logic [15:0] ACCEL_SCALE_RST = 16'd16;
  localparam logic [15:0] GYRO_SCALE_RST  = 16'd2000;
  localparam logic [15:0] ANGLE_SCALE_RST = 16'd180;

  // classified frame handed from front to back
  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         frame_type;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic [15:0]        mul;
  } frame_rec_t;

  // result item as packed on the output stream
  typedef struct packed {
    logic [4:0]         pad;
    logic signed [31:0] value_z;
    logic signed [31:0] value_y;
    logic signed [31:0] value_x;
    logic [7:0]         frame_type;
    logic [2:0]         status;
  } result_t;

endpackage

// ----- src/isfp_front.sv -----
// isfp_front: byte window, frame check, classification and scale registers
// depends on isfp_pkg
module isfp_front
  import isfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic       push_valid,
  input  logic       push_ready,
  output frame_rec_t push_rec
);

  logic [7:0]  window [HELD_LEN];
  logic [3:0]  fill_count;
  logic [15:0] accel_scale;
  logic [15:0] gyro_scale;
  logic [15:0] angle_scale;
  logic        full_now;
  logic        fire;
  logic        frame_ok;
  logic [7:0]  sum;

  // a result comes out only when the tenth held byte is followed by one more
  assign full_now = (fill_count >= 4'(HELD_LEN));
  assign s_tready = !full_now || push_ready;
  assign fire     = s_tvalid && s_tready;

  // checksum over held bytes
  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < HELD_LEN; i++) begin
      sum = sum + window[i];
    end
  end

  assign frame_ok = (window[0] == SYNC_BYTE) && ((window[1] & TYPE_MASK) == TYPE_MASK) &&
                    (sum == s_tdata);

  // classification
  always_comb begin
    push_rec.frame_type = window[1];
    push_rec.raw_x      = {window[3], window[2]};
    push_rec.raw_y      = {window[5], window[4]};
    push_rec.raw_z      = {window[7], window[6]};
    if (!frame_ok) begin
      push_rec.status = ST_SYNC_ERR;
      push_rec.mul    = 16'd0;
    end else begin
      unique case (window[1])
        TYPE_ACCEL: begin
          push_rec.status = ST_ACCEL;
          push_rec.mul    = accel_scale;
        end
        TYPE_GYRO: begin
          push_rec.status = ST_GYRO;
          push_rec.mul    = gyro_scale;
        end
        TYPE_ANGLE: begin
          push_rec.status = ST_ANGLE;
          push_rec.mul    = angle_scale;
        end
        TYPE_MAG: begin
          push_rec.status = ST_MAG;
          push_rec.mul    = MAG_MUL;
        end
        default: begin
          push_rec.status = ST_OTHER;
          push_rec.mul    = 16'd0;
        end
      endcase
    end
  end

  assign push_valid = fire && full_now;

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= 4'd0;
    end else if (fire) begin
      if (full_now) begin
        fill_count <= frame_ok ? 4'd0 : 4'(HELD_LEN);
      end else begin
        fill_count <= fill_count + 4'd1;
      end
    end
  end

  // held bytes: append, or slide by one on a failed check
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < HELD_LEN; i++) begin
        if (full_now) begin
          if (!frame_ok) begin
            window[i] <= (i == HELD_LEN - 1) ? s_tdata : window[(i + 1) % HELD_LEN];
          end
        end else if (fill_count == 4'(i)) begin
          window[i] <= s_tdata;
        end
      end
    end
  end

  // scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_scale <= ACCEL_SCALE_RST;
      gyro_scale  <= GYRO_SCALE_RST;
      angle_scale <= ANGLE_SCALE_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_ACCEL_SCALE: accel_scale <= cfg_data;
        REG_GYRO_SCALE:  gyro_scale  <= cfg_data;
        REG_ANGLE_SCALE: angle_scale <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/isfp_queue.sv -----
// isfp_queue: short fifo of classified frames between front and back
// depends on isfp_pkg and the assertion macro header
`include "imu_serial_frame_parser_macros.svh"
module isfp_queue
  import isfp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_rec_t push_rec,
  output logic       pop_valid,
  input  logic       pop_ready,
  output frame_rec_t pop_rec
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  frame_rec_t          mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                push;
  logic                pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ISFP_ASSERT_ALWAYS(a_count_bound, count <= CntW'(DEPTH), "queue count beyond depth")
  `ISFP_ASSERT_NEXT(a_pop_drops, pop && !push, count == $past(count) - 1'b1, "pop lost")
  `ISFP_ASSERT_NEXT(a_push_adds, push && !pop, count == $past(count) + 1'b1, "push lost")
  `ISFP_ASSERT_NEXT(a_rd_moves, pop, rd_ptr != $past(rd_ptr) || DEPTH == 1, "read pointer stuck")

endmodule

// ----- src/isfp_back.sv -----
// isfp_back: scales the three raw words and holds the result for the output
// depends on isfp_pkg
module isfp_back
  import isfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  frame_rec_t pop_rec,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    m_res
);

  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;
  logic signed [32:0] prod_z;
  logic signed [16:0] mul_s;

  assign mul_s     = $signed({1'b0, pop_rec.mul});
  assign prod_x    = pop_rec.raw_x * mul_s;
  assign prod_y    = pop_rec.raw_y * mul_s;
  assign prod_z    = pop_rec.raw_z * mul_s;
  assign pop_ready = !m_tvalid || m_tready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_ready) begin
      m_tvalid <= pop_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      m_res.pad        <= '0;
      m_res.status     <= pop_rec.status;
      m_res.frame_type <= pop_rec.frame_type;
      m_res.value_x    <= prod_x[31:0];
      m_res.value_y    <= prod_y[31:0];
      m_res.value_z    <= prod_z[31:0];
    end
  end

endmodule

// ----- src/imu_serial_frame_parser.sv -----
// imu_serial_frame_parser: top level of the 11-byte imu frame parser
// depends on isfp_pkg, isfp_front, isfp_queue, isfp_back
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] rx_byte
// m_*       out  m_tvalid/m_tready  m_tdata: status, frame_type, value_x/y/z
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// one byte per cycle is taken while s_tready is high; a completed frame is written into
// the queue on its last byte, then multiplied into the output register behind m_tvalid
// rst is synchronous and empties the byte window, the queue and the output
// the input stalls only on a frame-completing byte while the queue is full
// the output register and queue keep bytes flowing while m_tready is low, until the queue fills
module imu_serial_frame_parser
  import isfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // [2:0] status, [10:3] frame_type, [42:11] value_x,
                                  // [74:43] value_y, [106:75] value_z, rest zero
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic       push_valid;
  logic       push_ready;
  frame_rec_t push_rec;
  logic       pop_valid;
  logic       pop_ready;
  frame_rec_t pop_rec;
  result_t    m_res;

  isfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  isfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  isfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = m_res;

endmodule
